@@ rtl/fbc_pkg.sv @@
`default_nettype none

package fbc_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int FIELD_W       = 32;

  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 4;
  localparam int NUM_CFG_REGS  = 8;
  localparam int REG_SEL_W     = $clog2(NUM_CFG_REGS);
  localparam int HALF_W        = CFG_DATA_W / 2;
  localparam int COLS_PER_REG  = CFG_DATA_W / HALF_W;

  localparam int NUM_ROWS      = 4;
  localparam int NUM_COLS      = 4;
  localparam int NUM_AXES      = 3;
  localparam int NUM_PLANES    = 6;
  localparam int W_ROW         = NUM_ROWS - 1;
  localparam int D_COL         = NUM_COLS - 1;

  // plane coefficient is one bit wider than a matrix entry
  localparam int COEF_W        = COORD_WIDTH + 1;
  localparam int PROD_W        = COEF_W + COORD_WIDTH;
  // three products plus the shifted offset, exact
  localparam int ACC_W         = PROD_W + 2;

  typedef logic signed [FIELD_W-1:0]     field_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [CFG_DATA_W-1:0]         cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  typedef struct packed {
    logic adv_b;
    logic adv_c;
    logic adv_d;
  } pipe_ctl_t;

endpackage

`default_nettype wire

@@ rtl/fbc_box_if.sv @@
`default_nettype none

interface fbc_box_if;
  import fbc_pkg::*;

  logic   valid;
  logic   ready;
  field_t min_x;
  field_t min_y;
  field_t min_z;
  field_t max_x;
  field_t max_y;
  field_t max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);

endinterface

`default_nettype wire

@@ rtl/fbc_res_if.sv @@
`default_nettype none

interface fbc_res_if;

  logic valid;
  logic ready;
  logic visible;
  logic box_invalid;

  modport source (output valid, visible, box_invalid, input ready);
  modport sink (input valid, visible, box_invalid, output ready);

endinterface

`default_nettype wire

@@ rtl/fbc_cfg.sv @@
`default_nettype none

module fbc_cfg
  import fbc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire cfg_idx_t  cfg_index,
  input  wire cfg_data_t cfg_data,
  output coef_t          planes [NUM_PLANES][NUM_COLS]
);

  cfg_data_t regs_r [NUM_CFG_REGS];
  coord_t    mat [NUM_ROWS][NUM_COLS];
  coef_t     planes_nxt [NUM_PLANES][NUM_COLS];
  coef_t     planes_r [NUM_PLANES][NUM_COLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG_REGS; i++) regs_r[i] <= '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_CFG_REGS))) begin
      regs_r[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
    end
  end

  genvar r, c, p;
  generate
    for (r = 0; r < NUM_ROWS; r++) begin : g_row
      for (c = 0; c < NUM_COLS; c++) begin : g_col
        assign mat[r][c] = regs_r[r*COLS_PER_REG + c/COLS_PER_REG]
                                 [(c%COLS_PER_REG)*HALF_W +: COORD_WIDTH];
      end
    end

    // even planes: row W plus row; odd planes: row W minus row
    for (p = 0; p < NUM_PLANES; p++) begin : g_plane
      for (c = 0; c < NUM_COLS; c++) begin : g_coef
        coef_t w_ext;
        coef_t r_ext;
        assign w_ext = {mat[W_ROW][c][COORD_WIDTH-1], mat[W_ROW][c]};
        assign r_ext = {mat[p/2][c][COORD_WIDTH-1], mat[p/2][c]};
        if (p % 2 == 1) begin : g_minus
          assign planes_nxt[p][c] = w_ext - r_ext;
        end else begin : g_plus
          assign planes_nxt[p][c] = w_ext + r_ext;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        for (int j = 0; j < NUM_COLS; j++) planes_r[i][j] <= '0;
      end
    end else begin
      planes_r <= planes_nxt;
    end
  end

  assign planes = planes_r;

endmodule

`default_nettype wire

@@ rtl/fbc_plane_eval.sv @@
`default_nettype none

module fbc_plane_eval
  import fbc_pkg::*;
(
  input  wire logic      clk,
  input  wire pipe_ctl_t ctl,
  input  wire coef_t     coef [NUM_COLS],
  input  wire coord_t    lo [NUM_AXES],
  input  wire coord_t    hi [NUM_AXES],
  output logic           cull
);

  coord_t corner [NUM_AXES];
  prod_t  prod_nxt [NUM_AXES];
  acc_t   d_ext;

  prod_t  prod_b_r [NUM_AXES];
  acc_t   d_b_r;
  logic   zero_b_r;

  acc_t   sum01_c_r;
  acc_t   sum2d_c_r;
  logic   zero_c_r;

  acc_t   total;
  logic   cull_d_r;

  // farthest corner along the normal: max where the component is non-negative
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      corner[a]   = coef[a][COEF_W-1] ? lo[a] : hi[a];
      prod_nxt[a] = $signed(coef[a]) * $signed(corner[a]);
    end
  end

  assign d_ext = {{(ACC_W-COEF_W){coef[D_COL][COEF_W-1]}}, coef[D_COL]} <<< FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (ctl.adv_b) begin
      prod_b_r <= prod_nxt;
      d_b_r    <= d_ext;
      zero_b_r <= (coef[0] == '0) && (coef[1] == '0) && (coef[2] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_c) begin
      sum01_c_r <= {{(ACC_W-PROD_W){prod_b_r[0][PROD_W-1]}}, prod_b_r[0]}
                 + {{(ACC_W-PROD_W){prod_b_r[1][PROD_W-1]}}, prod_b_r[1]};
      sum2d_c_r <= {{(ACC_W-PROD_W){prod_b_r[2][PROD_W-1]}}, prod_b_r[2]} + d_b_r;
      zero_c_r  <= zero_b_r;
    end
  end

  assign total = sum01_c_r + sum2d_c_r;

  // a zero normal never culls
  always_ff @(posedge clk) begin
    if (ctl.adv_d) begin
      cull_d_r <= !zero_c_r && total[ACC_W-1];
    end
  end

  assign cull = cull_d_r;

endmodule

`default_nettype wire

@@ rtl/frustum_box_cull_top.sv @@
// Pipeline: a box taken on in_box passes registered stages a to e; out_res shows stage e.
// Throughput: one box per cycle, carried by 18 parallel 33x32 multipliers (one per
// plane and axis) in the second stage; a full stage stalls only behind a stalled next
// stage, the last one when out_res.ready is low. Reset (rst_n low, synchronous): clears all
// valid bits and the eight matrix registers to zero; plane coefficients follow in the next cycle.
`default_nettype none

module frustum_box_cull_top
  import fbc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  fbc_box_if.sink        in_box,
  fbc_res_if.source      out_res,
  input  wire logic      cfg_we,
  input  wire cfg_idx_t  cfg_index,
  input  wire cfg_data_t cfg_data
);

  coef_t     planes [NUM_PLANES][NUM_COLS];
  logic      cull [NUM_PLANES];
  logic [NUM_PLANES-1:0] cull_vec;

  logic      va_r, vb_r, vc_r, vd_r, ve_r;
  logic      adv_a, adv_b, adv_c, adv_d, adv_e;
  pipe_ctl_t ctl;

  coord_t    lo_a_r [NUM_AXES];
  coord_t    hi_a_r [NUM_AXES];
  logic      inv_b_r, inv_c_r, inv_d_r;
  logic      visible_e_r, invalid_e_r;

  // a stage moves when it is empty or the next one moves
  assign adv_e = !ve_r || out_res.ready;
  assign adv_d = !vd_r || adv_e;
  assign adv_c = !vc_r || adv_d;
  assign adv_b = !vb_r || adv_c;
  assign adv_a = !va_r || adv_b;

  assign ctl.adv_b = adv_b;
  assign ctl.adv_c = adv_c;
  assign ctl.adv_d = adv_d;

  assign in_box.ready = adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= in_box.valid;
      if (adv_b) vb_r <= va_r;
      if (adv_c) vc_r <= vb_r;
      if (adv_d) vd_r <= vc_r;
      if (adv_e) ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      lo_a_r[0] <= in_box.min_x[COORD_WIDTH-1:0];
      lo_a_r[1] <= in_box.min_y[COORD_WIDTH-1:0];
      lo_a_r[2] <= in_box.min_z[COORD_WIDTH-1:0];
      hi_a_r[0] <= in_box.max_x[COORD_WIDTH-1:0];
      hi_a_r[1] <= in_box.max_y[COORD_WIDTH-1:0];
      hi_a_r[2] <= in_box.max_z[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      inv_b_r <= (lo_a_r[0] > hi_a_r[0]) || (lo_a_r[1] > hi_a_r[1]) ||
                 (lo_a_r[2] > hi_a_r[2]);
    end
    if (adv_c) inv_c_r <= inv_b_r;
    if (adv_d) inv_d_r <= inv_c_r;
  end

  fbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  genvar p;
  generate
    for (p = 0; p < NUM_PLANES; p++) begin : g_plane
      fbc_plane_eval u_eval (
        .clk  (clk),
        .ctl  (ctl),
        .coef (planes[p]),
        .lo   (lo_a_r),
        .hi   (hi_a_r),
        .cull (cull[p])
      );
      assign cull_vec[p] = cull[p];
    end
  endgenerate

  // an invalid box passes whatever the planes say
  always_ff @(posedge clk) begin
    if (adv_e) begin
      visible_e_r <= inv_d_r || !(|cull_vec);
      invalid_e_r <= inv_d_r;
    end
  end

  assign out_res.valid       = ve_r;
  assign out_res.visible     = visible_e_r;
  assign out_res.box_invalid = invalid_e_r;

endmodule

`default_nettype wire

@@ rtl/fbc_checker.sv @@
`default_nettype none

module fbc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic visible,
  input wire logic box_invalid
);

  // an invalid box is never culled
  a_invalid_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (visible || !box_invalid))
    else $error("invalid box reported as culled");

  // input backs off only behind a stalled, full output
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(visible) && $stable(box_invalid)))
    else $error("stalled result changed");

endmodule

bind frustum_box_cull_top fbc_checker u_fbc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_box.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .visible     (out_res.visible),
  .box_invalid (out_res.box_invalid)
);

`default_nettype wire
